// ----- rtl/kvbmf_pkg.sv -----
package kvbmf_pkg;

	localparam logic [4:0] HDR_BYTES = 5'd24;

	localparam logic [7:0] MAGIC_REQ = 8'h80;
	localparam logic [7:0] MAGIC_RES = 8'h81;

	localparam logic [7:0] OP_GET     = 8'h00;
	localparam logic [7:0] OP_SET     = 8'h01;
	localparam logic [7:0] OP_ADD     = 8'h02;
	localparam logic [7:0] OP_REPLACE = 8'h03;
	localparam logic [7:0] OP_DELETE  = 8'h04;
	localparam logic [7:0] OP_INCR    = 8'h05;
	localparam logic [7:0] OP_DECR    = 8'h06;
	localparam logic [7:0] OP_QUIT    = 8'h07;
	localparam logic [7:0] OP_NOOP    = 8'h0A;
	localparam logic [7:0] OP_GETKQ   = 8'h0D;
	localparam logic [7:0] OP_APPEND  = 8'h0E;
	localparam logic [7:0] OP_PREPEND = 8'h0F;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_UNKNOWN   = 2'd2;
	localparam logic [1:0] ST_QUIT      = 2'd3;

	// raw message descriptor, front to back
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  opcode;
		logic [31:0] origin;
		logic [7:0]  extras_len;
		logic [31:0] body_size;
		logic [15:0] key_len;
		logic        with_flags;
		logic        resp_mode;
	} desc_t;

	// finished result, held in the output register
	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  opcode;
		logic [31:0] message_start;
		logic [32:0] message_length;
		logic [31:0] key_position;
		logic [15:0] key_length;
		logic        is_update;
		logic        is_end_marker;
		logic        more_follows;
	} result_t;

	typedef struct packed {
		logic stopped;
	} front_stat_t;

	function automatic logic op_updates(input logic [7:0] op);
		return op == OP_SET || op == OP_ADD || op == OP_REPLACE || op == OP_DELETE ||
			op == OP_INCR || op == OP_DECR || op == OP_APPEND || op == OP_PREPEND;
	endfunction

	function automatic logic op_known(input logic [7:0] op);
		return op_updates(op) || op == OP_GET || op == OP_GETKQ || op == OP_NOOP ||
			op == OP_QUIT;
	endfunction

endpackage

// ----- rtl/kvbmf_front.sv -----
module kvbmf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic [7:0]           data_byte,
	input  logic                 expect_response,
	output logic                 push,
	output kvbmf_pkg::desc_t     desc,
	output kvbmf_pkg::front_stat_t stat
);

	logic [4:0]  hdr_q, hdr_d;
	logic [31:0] body_rem_q, body_rem_d;
	logic [7:0]  op_q, op_d;
	logic [15:0] key_len_q, key_len_d;
	logic [7:0]  extras_q, extras_d;
	logic [31:0] body_size_q, body_size_d;
	logic [31:0] origin_q, origin_d;
	logic [31:0] pos_q, pos_d;
	logic        stopped_q, stopped_d;
	logic [31:0] body_dec;
	logic [7:0]  magic;

	assign magic    = expect_response ? kvbmf_pkg::MAGIC_RES : kvbmf_pkg::MAGIC_REQ;
	assign body_dec = body_rem_q - {31'd0, (body_rem_q != 32'd0)};

	always_comb begin
		hdr_d       = hdr_q;
		body_rem_d  = body_rem_q;
		op_d        = op_q;
		key_len_d   = key_len_q;
		extras_d    = extras_q;
		body_size_d = body_size_q;
		origin_d    = origin_q;
		pos_d       = pos_q;
		stopped_d   = stopped_q;
		push        = 1'b0;
		desc            = '0;
		desc.opcode     = op_q;
		desc.origin     = origin_q;
		desc.extras_len = extras_q;
		desc.body_size  = body_size_q;
		desc.key_len    = key_len_q;
		desc.resp_mode  = expect_response;
		if (accept && !stopped_q) begin
			pos_d = pos_q + 32'd1;
			if (hdr_q < kvbmf_pkg::HDR_BYTES) begin
				hdr_d = hdr_q + 5'd1;
				unique case (hdr_q)
					5'd0: begin
						origin_d    = pos_q;
						op_d        = '0;
						key_len_d   = '0;
						extras_d    = '0;
						body_size_d = '0;
					end
					5'd1: op_d = data_byte;
					5'd2, 5'd3: key_len_d = {key_len_q[7:0], data_byte};
					5'd4: extras_d = data_byte;
					5'd8, 5'd9, 5'd10, 5'd11: body_size_d = {body_size_q[23:0], data_byte};
					default: ;
				endcase
				if (hdr_q == 5'd0 && data_byte != magic) begin
					// bad magic: only status and start are reported
					push          = 1'b1;
					desc          = '0;
					desc.status   = kvbmf_pkg::ST_BAD_MAGIC;
					desc.origin   = pos_q;
					stopped_d     = 1'b1;
					hdr_d         = hdr_q;
				end else if (hdr_q == kvbmf_pkg::HDR_BYTES - 5'd1) begin
					if (!expect_response && !kvbmf_pkg::op_known(op_q)) begin
						push        = 1'b1;
						desc.status = kvbmf_pkg::ST_UNKNOWN;
						stopped_d   = 1'b1;
					end else if (!expect_response && op_q == kvbmf_pkg::OP_QUIT) begin
						push        = 1'b1;
						desc.status = kvbmf_pkg::ST_QUIT;
						stopped_d   = 1'b1;
					end else if (body_size_q == 32'd0) begin
						push            = 1'b1;
						desc.status     = kvbmf_pkg::ST_OK;
						desc.with_flags = 1'b1;
						hdr_d           = '0;
					end else begin
						body_rem_d = body_size_q;
					end
				end
			end else begin
				body_rem_d = body_dec;
				if (body_dec == 32'd0) begin
					push            = 1'b1;
					desc.status     = kvbmf_pkg::ST_OK;
					desc.with_flags = 1'b1;
					hdr_d           = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q       <= '0;
			body_rem_q  <= '0;
			op_q        <= '0;
			key_len_q   <= '0;
			extras_q    <= '0;
			body_size_q <= '0;
			origin_q    <= '0;
			pos_q       <= '0;
			stopped_q   <= 1'b0;
		end else begin
			hdr_q       <= hdr_d;
			body_rem_q  <= body_rem_d;
			op_q        <= op_d;
			key_len_q   <= key_len_d;
			extras_q    <= extras_d;
			body_size_q <= body_size_d;
			origin_q    <= origin_d;
			pos_q       <= pos_d;
			stopped_q   <= stopped_d;
		end
	end

	assign stat.stopped = stopped_q;

endmodule

// ----- rtl/kvbmf_queue.sv -----
module kvbmf_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kvbmf_pkg::desc_t push_desc,
	input  logic             pop,
	output logic             full,
	output logic             not_empty,
	output kvbmf_pkg::desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	kvbmf_pkg::desc_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == FULL_CNT;
	assign not_empty = count_q != '0;
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/kvbmf_back.sv -----
module kvbmf_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_not_empty,
	input  kvbmf_pkg::desc_t   q_head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output kvbmf_pkg::result_t out_res
);

	kvbmf_pkg::result_t res;
	logic               valid_q;
	logic               bare;

	assign pop  = q_not_empty && (!valid_q || out_ready);
	assign bare = q_head.status == kvbmf_pkg::ST_BAD_MAGIC;

	always_comb begin
		res                = '0;
		res.status         = q_head.status;
		res.message_start  = q_head.origin;
		if (!bare) begin
			res.opcode         = q_head.opcode;
			res.message_length = {1'b0, q_head.body_size} + 33'(kvbmf_pkg::HDR_BYTES);
			res.key_position   = q_head.origin + 32'(kvbmf_pkg::HDR_BYTES)
				+ {24'd0, q_head.extras_len};
			res.key_length     = q_head.key_len;
			res.is_update      = q_head.with_flags && !q_head.resp_mode
				&& kvbmf_pkg::op_updates(q_head.opcode);
			res.is_end_marker  = q_head.with_flags && q_head.opcode == kvbmf_pkg::OP_NOOP;
			res.more_follows   = q_head.with_flags && q_head.opcode == kvbmf_pkg::OP_GETKQ;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_res <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	assign out_valid = valid_q;

endmodule

// ----- rtl/kv_binary_message_framer.sv -----
// channel   | beat            | tdata / tuser / tlast
// ----------+-----------------+---------------------------------------------
// s_axis    | one stream byte | tdata[7:0] data_byte
// m_axis    | one descriptor  | tuser status, tlast is_end_marker, tdata rest
// cfg       | mode write      | cfg_wr_data = expect_response
//
// one byte per cycle sustained; s_tready drops only when the descriptor
// queue is full, i.e. when the result side stalls long enough to fill it
// a descriptor goes from the byte that ends its message through the front
// parser, the queue and the output register; the add for length and key
// position sits in the back stage
// reset clears counters, positions and the stopped flag; after an error or
// quit status the block keeps taking bytes and drops them until reset
module kv_binary_message_framer #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] data_byte
	output logic         m_tvalid,
	input  logic         m_tready,
	// [7:0] opcode, [39:8] message_start, [72:40] message_length,
	// [104:73] key_position, [120:105] key_length, [121] is_update,
	// [122] more_follows, [127:123] zero
	output logic [127:0] m_tdata,
	output logic [1:0]   m_tuser,   // [1:0] status
	output logic         m_tlast,   // is_end_marker
	input  logic         cfg_wr_en,
	input  logic         cfg_wr_data
);

	logic                      expect_response_q;
	logic                      accept;
	logic                      q_push, q_pop, q_full, q_not_empty;
	kvbmf_pkg::desc_t          q_in, q_head;
	kvbmf_pkg::front_stat_t    front_stat;
	kvbmf_pkg::result_t        res;

	// mode register; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_response_q <= 1'b0;
		end else if (cfg_wr_en) begin
			expect_response_q <= cfg_wr_data;
		end
	end

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// front: header parse, body count, classification
	kvbmf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.data_byte       (s_tdata),
		.expect_response (expect_response_q),
		.push            (q_push),
		.desc            (q_in),
		.stat            (front_stat)
	);

	// short queue decoupling parser from the result side
	kvbmf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_in),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// back: result arithmetic and output register
	kvbmf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.pop         (q_pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_res     (res)
	);

	assign m_tuser = res.status;
	assign m_tlast = res.is_end_marker;
	assign m_tdata = {5'd0, res.more_follows, res.is_update, res.key_length,
		res.key_position, res.message_length, res.message_start, res.opcode};

	// the front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("descriptor queue overflow");

	// nothing is produced once the parser has stopped
	a_stopped_silent: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.stopped |-> !q_push)
		else $error("descriptor after stop");

	// any non-ok status stops the parser
	a_error_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_in.status != kvbmf_pkg::ST_OK) |=> front_stat.stopped)
		else $error("error status without stop");

	// a bad magic result carries only status and start
	a_bad_magic_bare: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == kvbmf_pkg::ST_BAD_MAGIC)
		|-> (m_tdata[7:0] == 8'd0 && m_tdata[127:40] == 88'd0 && !m_tlast))
		else $error("bad magic result not cleared");

endmodule
